// File: rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared widths, codes and types for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int STAMP_W    = 64;
  localparam int CNT_W      = 32;
  localparam int OP_W       = 2;
  localparam int OUT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int SB_W       = 4;
  localparam int BB_W       = 6;
  localparam int WAYS_W     = 4;
  // room for a way count of up to sixteen
  localparam int WAYS_CMP_W = 5;

  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
  localparam logic [OP_W-1:0] OP_IFETCH = 2'd3;

  localparam logic [OUT_W-1:0] OUT_HIT     = 2'd0;
  localparam logic [OUT_W-1:0] OUT_FILL    = 2'd1;
  localparam logic [OUT_W-1:0] OUT_EVICT   = 2'd2;
  localparam logic [OUT_W-1:0] OUT_IGNORED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic               tag_match;
    logic               stamp_lt;
    logic               valid;
    logic [STAMP_W-1:0] stamp;
  } way_cmp_t;

endpackage

// File: rtl/salc_row_mem.sv
// ----------------------------------------------------------------------------
// salc_row_mem
// Set storage: one row per set holding every way. Registered read; a row not
// written since reset reads as all zero through a per-row valid flag.
// ----------------------------------------------------------------------------
module salc_row_mem #(
  parameter int ADDR_W = 8,
  parameter int DEPTH  = 256,
  parameter int ROW_W  = 904
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ROW_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ROW_W-1:0]  wr_data
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] data_r;
  logic             row_vld_r [DEPTH];
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        row_vld_r[i] <= 1'b0;
      end
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? data_r : '0;

endmodule

// File: rtl/salc_way_cmp.sv
// ----------------------------------------------------------------------------
// salc_way_cmp
// Shared way unit: picks one way out of a set row, checks its tag and
// compares its stamp with the oldest one seen so far.
// ----------------------------------------------------------------------------
module salc_way_cmp #(
  parameter int ADDR_BITS = 48,
  parameter int MAX_WAYS  = 8
) (
  input  logic [MAX_WAYS*(1+ADDR_BITS+salc_pkg::STAMP_W)-1:0] row,
  input  logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0]     way,
  input  logic [ADDR_BITS-1:0]                                 ref_tag,
  input  logic [salc_pkg::STAMP_W-1:0]                         best_stamp,
  output salc_pkg::way_cmp_t                                   res
);

  localparam int ENTRY_W = 1 + ADDR_BITS + salc_pkg::STAMP_W;

  logic [ENTRY_W-1:0]           entry;
  logic                         e_valid;
  logic [ADDR_BITS-1:0]         e_tag;
  logic [salc_pkg::STAMP_W-1:0] e_stamp;

  always_comb begin
    entry = row[way*ENTRY_W +: ENTRY_W];
    {e_valid, e_tag, e_stamp} = entry;
    res.valid     = e_valid;
    res.stamp     = e_stamp;
    res.tag_match = e_valid && (e_tag == ref_tag);
    res.stamp_lt  = e_stamp < best_stamp;
  end

endmodule

// File: rtl/set_assoc_lru_cache_sim_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_unit
// Trace-driven set-associative cache model with true LRU replacement.
// ----------------------------------------------------------------------------
// Input channel (in_*): one trace access per transfer, op and byte address.
// Result channel (out_*): one result per access: outcome, modify second-hit
// flag and the saturating hit, miss and eviction totals after the access.
// Configuration (cfg_*): set bits, block bits and ways in use; write only
// while idle.
// Sequence: an access reads the set row, walks the ways through a
// single tag/stamp compare unit (up to the first hit, at most ways_in_use
// ways), writes the row back and then presents the result. A modify makes
// both passes over the row; an instruction fetch skips the cache and goes
// straight to the result. The scan over the ways sets the rate.
// in_stall is high while an access is being worked on. A waiting result does
// not block a new access; only the final handover waits for out_stall.
// Reset clears the totals, the stamp counter and the per-set valid flags, so
// the whole cache reads empty at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_unit #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [salc_pkg::OP_W-1:0]        in_op,
  input  logic [ADDR_BITS-1:0]             in_address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [salc_pkg::OUT_W-1:0]       out_outcome,
  output logic                             out_second_hit,
  output logic [salc_pkg::CNT_W-1:0]       out_hit_count,
  output logic [salc_pkg::CNT_W-1:0]       out_miss_count,
  output logic [salc_pkg::CNT_W-1:0]       out_eviction_count,
  input  logic                             cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SET_W   = MAX_SET_BITS > 0 ? MAX_SET_BITS : 1;
  localparam int DEPTH   = 1 << MAX_SET_BITS;
  localparam int WAY_W   = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
  localparam int ENTRY_W = 1 + ADDR_BITS + salc_pkg::STAMP_W;
  localparam int ROW_W   = MAX_WAYS * ENTRY_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic [salc_pkg::SB_W-1:0]   set_bits_r;
  logic [salc_pkg::BB_W-1:0]   blk_bits_r;
  logic [salc_pkg::WAYS_W-1:0] ways_r;

  logic [salc_pkg::STAMP_W-1:0] stamp_cnt_r;
  logic [salc_pkg::CNT_W-1:0]   hits_r, misses_r, evicts_r;

  logic [salc_pkg::OP_W-1:0]  op_r;
  logic [SET_W-1:0]           set_r;
  logic [ADDR_BITS-1:0]       tag_r;
  logic                       second_pass_r;
  logic [salc_pkg::OUT_W-1:0] first_out_r;
  logic                       second_hit_r;

  logic [WAY_W-1:0]             w_r;
  logic                         hit_found_r, inv_found_r;
  logic [WAY_W-1:0]             hit_way_r, inv_way_r, vic_way_r;
  logic [salc_pkg::STAMP_W-1:0] vic_stamp_r;

  logic                         out_valid_r;
  logic [salc_pkg::OUT_W-1:0]   out_outcome_r;
  logic                         out_second_r;
  logic [salc_pkg::CNT_W-1:0]   out_hits_r, out_misses_r, out_evicts_r;

  logic                  in_xfer, can_load, last_way;
  logic [salc_pkg::SB_W-1:0]       sb;
  logic [salc_pkg::WAYS_CMP_W-1:0] ways_eff, last_idx;
  logic [ADDR_BITS-1:0]  a_shift, tag_in;
  logic [SET_W-1:0]      set_mask, set_in;
  logic [ROW_W-1:0]      rd_row, wr_row;
  logic [WAY_W-1:0]      sel_way;
  logic [salc_pkg::OUT_W-1:0] acc_out;
  salc_pkg::way_cmp_t    cmp;

  // ---- configuration decode and address split ----
  always_comb begin
    if (set_bits_r > salc_pkg::SB_W'(MAX_SET_BITS)) begin
      sb = salc_pkg::SB_W'(MAX_SET_BITS);
    end else begin
      sb = set_bits_r;
    end
    if (ways_r == '0) begin
      ways_eff = salc_pkg::WAYS_CMP_W'(1);
    end else if ({1'b0, ways_r} > salc_pkg::WAYS_CMP_W'(MAX_WAYS)) begin
      ways_eff = salc_pkg::WAYS_CMP_W'(MAX_WAYS);
    end else begin
      ways_eff = {1'b0, ways_r};
    end
    last_idx = ways_eff - salc_pkg::WAYS_CMP_W'(1);
    last_way = salc_pkg::WAYS_CMP_W'(w_r) == last_idx;
    a_shift  = in_address >> blk_bits_r;
    set_mask = ~({SET_W{1'b1}} << sb);
    set_in   = a_shift[SET_W-1:0] & set_mask;
    tag_in   = a_shift >> sb;
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign can_load = !out_valid_r || !out_stall;

  // ---- storage and the shared way unit ----
  salc_row_mem #(
    .ADDR_W (SET_W),
    .DEPTH  (DEPTH),
    .ROW_W  (ROW_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (state_r == S_READ),
    .rd_addr (set_r),
    .rd_data (rd_row),
    .wr_en   (state_r == S_WRITE),
    .wr_addr (set_r),
    .wr_data (wr_row)
  );

  salc_way_cmp #(
    .ADDR_BITS (ADDR_BITS),
    .MAX_WAYS  (MAX_WAYS)
  ) u_cmp (
    .row        (rd_row),
    .way        (w_r),
    .ref_tag    (tag_r),
    .best_stamp (vic_stamp_r),
    .res        (cmp)
  );

  // ---- write-back: hit way, else first free way, else oldest ----
  always_comb begin
    if (hit_found_r) begin
      sel_way = hit_way_r;
      acc_out = salc_pkg::OUT_HIT;
    end else if (inv_found_r) begin
      sel_way = inv_way_r;
      acc_out = salc_pkg::OUT_FILL;
    end else begin
      sel_way = vic_way_r;
      acc_out = salc_pkg::OUT_EVICT;
    end
    wr_row = rd_row;
    wr_row[sel_way*ENTRY_W +: ENTRY_W] = {1'b1, tag_r, stamp_cnt_r};
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_op == salc_pkg::OP_IFETCH) ? S_DONE : S_READ;
        end
      end
      S_READ:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (cmp.tag_match || last_way) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (op_r == salc_pkg::OP_MODIFY && !second_pass_r) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      set_bits_r    <= salc_pkg::SB_W'(4);
      blk_bits_r    <= salc_pkg::BB_W'(4);
      ways_r        <= salc_pkg::WAYS_W'(1);
      stamp_cnt_r   <= '0;
      hits_r        <= '0;
      misses_r      <= '0;
      evicts_r      <= '0;
      second_pass_r <= 1'b0;
      hit_found_r   <= 1'b0;
      inv_found_r   <= 1'b0;
      w_r           <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          salc_pkg::CFG_SET_BITS:   set_bits_r <= cfg_wdata[salc_pkg::SB_W-1:0];
          salc_pkg::CFG_BLOCK_BITS: blk_bits_r <= cfg_wdata;
          salc_pkg::CFG_WAYS:       ways_r     <= cfg_wdata[salc_pkg::WAYS_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          second_pass_r <= 1'b0;
        end
        S_READ: begin
          w_r         <= '0;
          hit_found_r <= 1'b0;
          inv_found_r <= 1'b0;
        end
        S_SCAN: begin
          if (!inv_found_r && !cmp.valid) begin
            inv_found_r <= 1'b1;
          end
          if (cmp.tag_match) begin
            hit_found_r <= 1'b1;
          end else if (!last_way) begin
            w_r <= w_r + WAY_W'(1);
          end
        end
        S_WRITE: begin
          stamp_cnt_r <= stamp_cnt_r + salc_pkg::STAMP_W'(1);
          if (hit_found_r) begin
            if (hits_r != salc_pkg::CNT_MAX) hits_r <= hits_r + salc_pkg::CNT_W'(1);
          end else begin
            if (misses_r != salc_pkg::CNT_MAX) misses_r <= misses_r + salc_pkg::CNT_W'(1);
          end
          if (!hit_found_r && !inv_found_r && evicts_r != salc_pkg::CNT_MAX) begin
            evicts_r <= evicts_r + salc_pkg::CNT_W'(1);
          end
          second_pass_r <= 1'b1;
        end
        default: ;
      endcase

      if (state_r == S_DONE && can_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r         <= in_op;
      set_r        <= set_in;
      tag_r        <= tag_in;
      first_out_r  <= salc_pkg::OUT_IGNORED;
      second_hit_r <= 1'b0;
    end
    if (state_r == S_SCAN) begin
      if (w_r == '0 || cmp.stamp_lt) begin
        vic_way_r   <= w_r;
        vic_stamp_r <= cmp.stamp;
      end
      if (!inv_found_r && !cmp.valid) begin
        inv_way_r <= w_r;
      end
      if (cmp.tag_match) begin
        hit_way_r <= w_r;
      end
    end
    if (state_r == S_WRITE) begin
      if (second_pass_r) begin
        second_hit_r <= hit_found_r;
      end else begin
        first_out_r <= acc_out;
      end
    end
    if (state_r == S_DONE && can_load) begin
      out_outcome_r <= first_out_r;
      out_second_r  <= second_hit_r;
      out_hits_r    <= hits_r;
      out_misses_r  <= misses_r;
      out_evicts_r  <= evicts_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_outcome        = out_outcome_r;
  assign out_second_hit     = out_second_r;
  assign out_hit_count      = out_hits_r;
  assign out_miss_count     = out_misses_r;
  assign out_eviction_count = out_evicts_r;

  // ---- assertions ----
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n) in_xfer |=> in_stall
  ) else $error("access accepted but block not busy");

  a_modify_second_hits: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE && second_pass_r) |-> hit_found_r
  ) else $error("second access of a modify missed");

  a_totals_monotonic: assert property (
    @(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (hits_r >= $past(hits_r) && misses_r >= $past(misses_r)
                      && evicts_r >= $past(evicts_r))
  ) else $error("a running total went down");

endmodule

// File: tb/sv/tb_set_assoc_lru_cache_sim_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_sim_unit
// Self-checking bench for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
// Each trace access is fed through a cycle-free predictor of the cache (its
// own tag, valid and recency store, geometry registers and saturating
// totals). The result that the predictor expects is queued, and every result
// transfer is checked field by field against the oldest entry. Directed
// tests cover reset geometry, LRU victim choice and the geometry extremes.
// Random phases then run many geometries with small tag pools, so that hits,
// fills and evictions all occur. Both channels idle at random, and one test
// holds the result side off for a long stretch.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_sim_unit;
  import salc_pkg::*;

  localparam int MAX_SET_BITS = 8;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_BITS    = 48;
  localparam int NUM_LINES    = (1 << MAX_SET_BITS) * MAX_WAYS;

  localparam logic [OP_W-1:0]      OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0]      OP_STORE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int IDLE_PCT     = 37;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE       = 32;

  typedef struct packed {
    logic [OUT_W-1:0] outcome;
    logic             second_hit;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
  } cache_result_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_op      = '0;
  logic [ADDR_BITS-1:0]  in_address = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [OUT_W-1:0]      out_outcome;
  logic                  out_second_hit;
  logic [CNT_W-1:0]      out_hit_count;
  logic [CNT_W-1:0]      out_miss_count;
  logic [CNT_W-1:0]      out_eviction_count;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // predictor state
  logic                 line_valid [NUM_LINES];
  logic [ADDR_BITS-1:0] line_tag   [NUM_LINES];
  logic [STAMP_W-1:0]   line_stamp [NUM_LINES];
  logic [STAMP_W-1:0]   stamp_next;
  logic [CNT_W-1:0]     hits_total, misses_total, evictions_total;
  logic [SB_W-1:0]      cur_set_bits;
  logic [BB_W-1:0]      cur_block_bits;
  logic [WAYS_W-1:0]    cur_ways;

  cache_result_t pending_results[$];
  cache_result_t due;
  int            fail_count    = 0;
  bit            no_idle       = 1'b0;
  int unsigned   hold_requests = 0;
  int unsigned   holds_served  = 0;
  int            hold_left     = 0;
  int            quiet_cycles  = 0;

  set_assoc_lru_cache_sim_unit #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_BITS    (ADDR_BITS)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_outcome        (out_outcome),
    .out_second_hit     (out_second_hit),
    .out_hit_count      (out_hit_count),
    .out_miss_count     (out_miss_count),
    .out_eviction_count (out_eviction_count),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int eff_set_bits();
    return (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cur_set_bits);
  endfunction

  function automatic int eff_ways();
    if (cur_ways == 0) return 1;
    return (cur_ways > MAX_WAYS) ? MAX_WAYS : int'(cur_ways);
  endfunction

  // One cache access against the predictor store.
  function automatic logic [OUT_W-1:0] cache_access(input logic [ADDR_BITS-1:0] addr);
    int                   sb, nw, set_idx, base, victim;
    logic [ADDR_BITS-1:0] blk, tag;
    sb      = eff_set_bits();
    nw      = eff_ways();
    blk     = addr >> cur_block_bits;   // shifts of 48 and up leave zero
    set_idx = int'(blk[7:0]) & ((1 << sb) - 1);
    tag     = blk >> sb;
    base    = set_idx * MAX_WAYS;
    for (int w = 0; w < nw; w++) begin
      if (line_valid[base+w] && line_tag[base+w] == tag) begin
        line_stamp[base+w] = stamp_next;
        stamp_next++;
        if (hits_total != CNT_MAX) hits_total++;
        return OUT_HIT;
      end
    end
    if (misses_total != CNT_MAX) misses_total++;
    for (int w = 0; w < nw; w++) begin
      if (!line_valid[base+w]) begin
        line_valid[base+w] = 1'b1;
        line_tag[base+w]   = tag;
        line_stamp[base+w] = stamp_next;
        stamp_next++;
        return OUT_FILL;
      end
    end
    // oldest stamp goes, lowest way on a tie
    victim = 0;
    for (int w = 1; w < nw; w++) begin
      if (line_stamp[base+w] < line_stamp[base+victim]) victim = w;
    end
    line_tag[base+victim]   = tag;
    line_stamp[base+victim] = stamp_next;
    stamp_next++;
    if (evictions_total != CNT_MAX) evictions_total++;
    return OUT_EVICT;
  endfunction

  function automatic void predict_access(input logic [OP_W-1:0] op,
                                         input logic [ADDR_BITS-1:0] addr);
    cache_result_t r;
    r.outcome    = OUT_IGNORED;
    r.second_hit = 1'b0;
    if (op != OP_IFETCH) begin
      r.outcome = cache_access(addr);
      if (op == OP_MODIFY) r.second_hit = (cache_access(addr) == OUT_HIT);
    end
    r.hits      = hits_total;
    r.misses    = misses_total;
    r.evictions = evictions_total;
    pending_results.push_back(r);
  endfunction

  // Build an address from tag, set and offset under the current geometry.
  function automatic logic [ADDR_BITS-1:0] compose_address(input logic [63:0] tag_v,
                                                           input int set_v,
                                                           input logic [63:0] off_v);
    int           sb;
    logic [127:0] a;
    sb = eff_set_bits();
    a  = 128'(tag_v);
    a  = (a << sb) | 128'(set_v & ((1 << sb) - 1));
    a  = (a << cur_block_bits) | (128'(off_v) & ((128'd1 << cur_block_bits) - 128'd1));
    return a[ADDR_BITS-1:0];
  endfunction

  function automatic logic [OP_W-1:0] OP_OP_pick(input int n);
    return OP_W'(n % 4);
  endfunction

  task automatic send_access(input logic [OP_W-1:0] op, input logic [ADDR_BITS-1:0] addr);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_address <= addr;
    do @(posedge clk); while (in_stall);
    predict_access(op, addr);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Geometry writes, optionally followed by a write to the spare index.
  task automatic set_geometry(input logic [5:0] sb_val, input logic [5:0] bb_val,
                              input logic [5:0] ways_val, input bit with_unused);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx[0] = CFG_SET_BITS;   val[0] = sb_val;
    idx[1] = CFG_BLOCK_BITS; val[1] = bb_val;
    idx[2] = CFG_WAYS;       val[2] = ways_val;
    idx[3] = CFG_UNUSED;     val[3] = CFG_DATA_W'($urandom);
    wait_idle();
    for (int i = 0; i < (with_unused ? 4 : 3); i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      case (idx[i])
        CFG_SET_BITS:   cur_set_bits   = val[i][SB_W-1:0];
        CFG_BLOCK_BITS: cur_block_bits = val[i];
        CFG_WAYS:       cur_ways       = val[i][WAYS_W-1:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random_phase(input logic [5:0] sb_val, input logic [5:0] bb_val,
                                  input logic [5:0] ways_val, input int n_items);
    logic [63:0]          tag_pool [12];
    int                   set_pool [4];
    int                   n_tags, pick, set_mask;
    logic [OP_W-1:0]      op;
    logic [ADDR_BITS-1:0] addr;
    set_geometry(sb_val, bb_val, ways_val, 1'b0);
    set_mask = (1 << eff_set_bits()) - 1;
    // a few tags more than there are ways keeps hits and evictions balanced
    n_tags = eff_ways() + $urandom_range(1, 3);
    for (int i = 0; i < n_tags; i++) begin
      tag_pool[i] = $urandom_range(1) ? {$urandom, $urandom} : 64'($urandom_range(15));
    end
    for (int i = 0; i < 3; i++) set_pool[i] = int'($urandom) & set_mask;
    set_pool[3] = set_mask;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      op   = (pick < 35) ? OP_LOAD : (pick < 65) ? OP_STORE :
             (pick < 90) ? OP_MODIFY : OP_IFETCH;
      if ($urandom_range(99) < 15)
        addr = ADDR_BITS'({$urandom, $urandom});
      else
        addr = compose_address(tag_pool[$urandom_range(n_tags - 1)],
                               set_pool[$urandom_range(3)], {$urandom, $urandom});
      send_access(op, addr);
    end
  endtask

  // Reset geometry: 16 sets, 16-byte blocks, direct mapped.
  task automatic test_reset_defaults();
    send_access(OP_LOAD,   48'h0);
    send_access(OP_STORE,  48'h8);
    send_access(OP_LOAD,   48'h100);
    send_access(OP_MODIFY, 48'h100);
    send_access(OP_MODIFY, 48'h200);
    send_access(OP_IFETCH, 48'h200);
    send_access(OP_LOAD,   48'hFFFF_FFFF_FFFF);
    send_access(OP_STORE,  48'hFFFF_FFFF_FFFF);
    send_access(OP_IFETCH, 48'h0);
  endtask

  // Single set, four ways: victim is the least recently touched way; lines
  // beyond a reduced way count survive and hit again once restored.
  task automatic test_lru_replacement();
    set_geometry(6'd0, 6'd0, 6'd4, 1'b1);
    for (int t = 1; t <= 4; t++) send_access(OP_LOAD, ADDR_BITS'(t));
    send_access(OP_LOAD,  48'd1);
    send_access(OP_LOAD,  48'd5);
    send_access(OP_STORE, 48'd2);
    set_geometry(6'd0, 6'd0, 6'd2, 1'b0);
    send_access(OP_LOAD,  48'd4);
    set_geometry(6'd0, 6'd0, 6'd4, 1'b0);
    send_access(OP_LOAD,  48'd2);
    send_access(OP_MODIFY, 48'd3);
  endtask

  // Oversized set bits, block offset past the address, zero ways.
  task automatic test_config_extremes();
    set_geometry(6'h3F, 6'd63, 6'd0, 1'b1);
    send_access(OP_LOAD,   48'hFFFF_FFFF_FFFF);
    send_access(OP_MODIFY, 48'h0);
    set_geometry(6'd8, 6'd40, 6'd8, 1'b0);
    send_access(OP_LOAD,   48'hFFFF_FFFF_FFFF);
    send_access(OP_STORE,  48'h00FF_0000_0000);
  endtask

  // Result side held off while the sender keeps offering, then a full drain.
  task automatic test_backpressure();
    set_geometry(6'd2, 6'd3, 6'd3, 1'b0);
    no_idle = 1'b1;
    hold_requests++;
    for (int n = 0; n < 24; n++) begin
      send_access(OP_OP_pick(n), compose_address(64'($urandom_range(5)),
                                                 $urandom_range(3), 64'($urandom)));
    end
    wait_idle();
    no_idle = 1'b0;
    run_random_phase(6'd2, 6'd3, 6'd3, 30);
  endtask

  task automatic test_steady_stream();
    no_idle = 1'b1;
    run_random_phase(6'd3, 6'd4, 6'd4, 150);
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_random_geometries();
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: run_random_phase(6'd4,  6'd4,  6'd1,  120);
        1: run_random_phase(6'd0,  6'd0,  6'd1,  120);
        2: run_random_phase(6'd0,  6'd0,  6'd8,  120);
        3: run_random_phase(6'd8,  6'd40, 6'd8,  120);
        4: run_random_phase(6'd15, 6'd6,  6'd4,  120);
        5: run_random_phase(6'd3,  6'd63, 6'd2,  120);
        6: run_random_phase(6'd2,  6'd47, 6'd15, 120);
        7: run_random_phase(6'd8,  6'd0,  6'd0,  120);
        default: run_random_phase(6'($urandom_range(15)), 6'($urandom_range(63)),
                                  6'($urandom_range(15)), 120);
      endcase
    end
  endtask

  // Result side: random stall, none under no_idle, or a long hold on request.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing outstanding");
        fail_count++;
      end else begin
        due = pending_results.pop_front();
        if (out_outcome !== due.outcome) begin
          $error("outcome: expected %0d, got %0d", due.outcome, out_outcome);
          fail_count++;
        end
        if (out_second_hit !== due.second_hit) begin
          $error("second_hit: expected %0d, got %0d", due.second_hit, out_second_hit);
          fail_count++;
        end
        if (out_hit_count !== due.hits) begin
          $error("hit_count: expected %0d, got %0d", due.hits, out_hit_count);
          fail_count++;
        end
        if (out_miss_count !== due.misses) begin
          $error("miss_count: expected %0d, got %0d", due.misses, out_miss_count);
          fail_count++;
        end
        if (out_eviction_count !== due.evictions) begin
          $error("eviction_count: expected %0d, got %0d", due.evictions,
                 out_eviction_count);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without a transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_LINES; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i]   = '0;
      line_stamp[i] = '0;
    end
    stamp_next      = '0;
    hits_total      = '0;
    misses_total    = '0;
    evictions_total = '0;
    cur_set_bits    = 4'd4;
    cur_block_bits  = 6'd4;
    cur_ways        = 4'd1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_lru_replacement();
    test_config_extremes();
    test_backpressure();
    test_steady_stream();
    test_random_geometries();
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/salc_pkg.sv
rtl/salc_row_mem.sv
rtl/salc_way_cmp.sv
rtl/set_assoc_lru_cache_sim_unit.sv
tb/sv/tb_set_assoc_lru_cache_sim_unit.sv
